// ----- src/mrob_pkg.sv -----
// Package for the multi-reader overwrite ring buffer.
// Holds opcodes, status codes and the struct between front and back ends.
// No dependencies.
package mrob_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned RDR_W = 3;
  localparam int unsigned SIZE_W = 13;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_ATTACH = 2'd2;
  localparam logic [OP_W-1:0] OP_DETACH = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOT_ATT = 2'd2;

  localparam logic [0:0] REG_BUFFER_SIZE = 1'd0;

  // One classified word from the front end to the back end.
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [7:0] data_byte;
    logic [RDR_W-1:0] reader;
  } op_word_t;

endpackage

// ----- src/mrob_ram.sv -----
// Generic single-port RAM with a registered read.
// Parameterised in width and depth; no dependencies.
module mrob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- src/mrob_front.sv -----
// Front end: accepts operation words into a two-entry queue.
// Depends on mrob_pkg.
module mrob_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mrob_pkg::op_word_t in_word,
  output logic               q_valid,
  output mrob_pkg::op_word_t q_word,
  input  logic               q_take
);
  import mrob_pkg::*;

  op_word_t slot [2];
  logic     rd_ptr;
  logic     wr_ptr;
  logic [1:0] fill;
  logic     do_push;

  assign full = fill[1];
  assign do_push = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_word = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= in_word;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, q_take};
    end
  end

`ifndef SYNTH
  a_no_take_empty: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("queue taken while empty");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
      (full && !q_take) |=> full)
    else $error("full dropped without a take");
`endif
endmodule

// ----- src/mrob_back.sv -----
// Back end: executes one operation at a time against reader state and the
// byte store, and holds the result word until it is popped.
// Depends on mrob_pkg and mrob_ram.
module mrob_back #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned NUM_READERS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [12:0]        size_reg,
  input  logic               q_valid,
  input  mrob_pkg::op_word_t q_word,
  output logic               q_take,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [7:0]         read_byte,
  output logic [12:0]        available,
  output logic [31:0]        truncated
);
  import mrob_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam logic [COUNT_BITS-1:0] TMAX = '1;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_RDAT = 2'b10
  } state_t;

  state_t state;
  logic [PW-1:0] wpos;
  logic [PW-1:0] rpos [NUM_READERS];
  logic [CW-1:0] rcnt [NUM_READERS];
  logic [COUNT_BITS-1:0] tcnt [NUM_READERS];
  logic [NUM_READERS-1:0] att;

  logic out_full;
  logic [CW-1:0] size;
  logic [RW-1:0] ridx;
  logic in_range;
  logic valid;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_rdata;
  logic [RW-1:0] pend_r;
  logic [PW-1:0] sel_pos;
  logic [CW-1:0] sel_cnt;
  logic [COUNT_BITS-1:0] sel_trunc;

  // Effective size: zero behaves as one, anything above DEPTH as DEPTH.
  always_comb begin
    if (size_reg == 13'd0) begin
      size = CW'(1);
    end else if ({19'd0, size_reg} > 32'(DEPTH)) begin
      size = CW'(DEPTH);
    end else begin
      size = CW'(size_reg);
    end
  end

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] s);
    logic [PW:0] n;
    n = {1'b0, p} + 1'b1;
    adv = (n >= {{(PW+1-CW){1'b0}}, s}) ? '0 : n[PW-1:0];
  endfunction

  assign ridx = q_word.reader[RW-1:0];
  assign in_range = ({29'd0, q_word.reader} < 32'(NUM_READERS));
  assign valid = in_range && att[ridx];
  assign sel_pos = rpos[ridx];
  assign sel_cnt = rcnt[ridx];
  assign sel_trunc = tcnt[ridx];

  assign empty = !out_full;
  assign q_take = (state == S_EXEC) && q_valid && (!out_full || pop);
  assign ram_we = q_take && (q_word.opcode == OP_WRITE);
  assign ram_addr = ram_we ? wpos[AW-1:0] : sel_pos[AW-1:0];

  mrob_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(q_word.data_byte), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXEC;
      out_full <= 1'b0;
      wpos <= '0;
      att <= '0;
      for (int i = 0; i < NUM_READERS; i++) begin
        rpos[i] <= '0;
        rcnt[i] <= '0;
        tcnt[i] <= '0;
      end
    end else begin
      if (pop && out_full) begin
        out_full <= 1'b0;
      end
      case (state)
        S_EXEC: begin
          if (q_take) begin
            read_byte <= 8'd0;
            available <= 13'(valid ? sel_cnt : '0);
            truncated <= 32'(valid ? sel_trunc : '0);
            status <= ST_OK;
            out_full <= 1'b1;
            case (q_word.opcode)
              OP_WRITE: begin
                for (int i = 0; i < NUM_READERS; i++) begin
                  if (att[i]) begin
                    if (rcnt[i] >= size) begin
                      rcnt[i] <= size;
                      rpos[i] <= adv(rpos[i], size);
                      if (tcnt[i] != TMAX) begin
                        tcnt[i] <= tcnt[i] + 1'b1;
                      end
                    end else begin
                      rcnt[i] <= rcnt[i] + 1'b1;
                    end
                  end
                end
                wpos <= adv(wpos, size);
                if (valid) begin
                  if (sel_cnt >= size) begin
                    available <= 13'(size);
                    truncated <= 32'((sel_trunc != TMAX) ? sel_trunc + 1'b1 : sel_trunc);
                  end else begin
                    available <= 13'(sel_cnt + 1'b1);
                  end
                end
              end
              OP_READ: begin
                if (!valid) begin
                  status <= ST_NOT_ATT;
                end else if (sel_cnt == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  // The result waits in S_RDAT for the store's registered read.
                  rpos[ridx] <= adv(sel_pos, size);
                  rcnt[ridx] <= sel_cnt - 1'b1;
                  available <= 13'(sel_cnt - 1'b1);
                  pend_r <= ridx;
                  out_full <= 1'b0;
                  state <= S_RDAT;
                end
              end
              OP_ATTACH: begin
                if (in_range) begin
                  att[ridx] <= 1'b1;
                  rpos[ridx] <= wpos;
                  rcnt[ridx] <= '0;
                  tcnt[ridx] <= '0;
                  available <= 13'd0;
                  truncated <= 32'd0;
                end else begin
                  status <= ST_NOT_ATT;
                end
              end
              default: begin
                available <= 13'd0;
                truncated <= 32'd0;
                if (valid) begin
                  att[ridx] <= 1'b0;
                  rpos[ridx] <= '0;
                  rcnt[ridx] <= '0;
                  tcnt[ridx] <= '0;
                end else begin
                  status <= ST_NOT_ATT;
                end
              end
            endcase
          end
        end
        S_RDAT: begin
          read_byte <= ram_rdata;
          out_full <= 1'b1;
          state <= S_EXEC;
        end
        default: state <= S_EXEC;
      endcase
    end
  end

`ifndef SYNTH
  a_state_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_rdat_then_result: assert property (@(posedge clk) disable iff (rst)
      (state == S_RDAT) |=> (out_full && state == S_EXEC))
    else $error("read result not delivered");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
      (out_full && !pop) |=> out_full)
    else $error("result lost before pop");
  a_pend_used: assert property (@(posedge clk) disable iff (rst)
      (state == S_RDAT) |-> att[pend_r])
    else $error("pending read of detached reader");
`endif
endmodule

// ----- src/multi_reader_overwrite_ring_buffer_unit.sv -----
// Multi-reader overwrite ring buffer, top level.
// Path: a pushed word goes through the front queue to the result register;
// a successful read also waits in S_RDAT for the store's registered read.
// The single result register stalls the queue until it is empty or popped.
// Reset (rst, synchronous): no reader attached, positions zero, size 4096.
module multi_reader_overwrite_ring_buffer_unit #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned NUM_READERS = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  reader,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic [12:0] available,
  output logic [31:0] truncated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrob_pkg::*;

  logic [12:0] size_reg;
  logic q_valid;
  logic q_take;
  op_word_t in_word;
  op_word_t q_word;

  assign pready = 1'b1;
  assign in_word = '{opcode: opcode, data_byte: data_byte, reader: reader};
  assign prdata = (paddr == REG_BUFFER_SIZE) ? {19'd0, size_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= 13'd4096;
    end else if (psel && penable && pwrite && (paddr == REG_BUFFER_SIZE)) begin
      size_reg <= pwdata[12:0];
    end
  end

  mrob_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
  );

  mrob_back #(.DEPTH(DEPTH), .NUM_READERS(NUM_READERS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst(rst), .size_reg(size_reg), .q_valid(q_valid), .q_word(q_word),
    .q_take(q_take), .empty(empty), .pop(pop), .status(status), .read_byte(read_byte),
    .available(available), .truncated(truncated)
  );
endmodule
